// ===== rtl/core/bde_pkg.sv =====
package bde_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 9;
   localparam int unsigned CMD_W  = 3;
   localparam int unsigned STS_W  = 2;

   localparam logic signed [DATA_W-1:0] DATA_NONE = '1;
   localparam logic signed [DATA_W-1:0] DATA_ZERO = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_POP_FRONT  = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ_AT    = 3'd4,
      CMD_DROP_FRONT = 3'd5
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_type;

endpackage

// ===== rtl/core/bde_if.sv =====
interface bde_req_if;
   logic                               valid;
   logic                               ready;
   logic [bde_pkg::CMD_W-1:0]          cmd;
   logic signed [bde_pkg::DATA_W-1:0]  value;
   logic [bde_pkg::POS_W-1:0]          position;
   logic [bde_pkg::POS_W-1:0]          drop_count;

   modport source (output valid, cmd, value, position, drop_count, input ready);
   modport sink   (input valid, cmd, value, position, drop_count, output ready);
endinterface

interface bde_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bde_pkg::DATA_W-1:0]  data;
   logic [bde_pkg::STS_W-1:0]          status;

   modport source (output valid, data, status, input ready);
   modport sink   (input valid, data, status, output ready);
endinterface

// ===== rtl/core/bde_ctrl.sv =====
module bde_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bde_pkg::ctl_type ctl
);

   bde_pkg::state_type state_ff;
   bde_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bde_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bde_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = bde_pkg::FSM_EXEC;
            end
         end
         bde_pkg::FSM_EXEC: begin
            state_in = bde_pkg::FSM_RESP;
         end
         bde_pkg::FSM_RESP: begin
            if (rsp_ready) begin
               state_in = bde_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = bde_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctl       = '0;
      unique case (state_ff)
         bde_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         bde_pkg::FSM_EXEC: begin
            ctl.exec = 1'b1;
         end
         bde_pkg::FSM_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> ctl.exec)
      else $error("exec did not follow request load");

   a_exec_then_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> rsp_valid)
      else $error("response did not follow exec");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

endmodule

// ===== rtl/core/bde_dpath.sv =====
module bde_dpath #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bde_pkg::ctl_type                   ctl,
   input  logic [bde_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [bde_pkg::DATA_W-1:0]  req_value,
   input  logic [bde_pkg::POS_W-1:0]          req_position,
   input  logic [bde_pkg::POS_W-1:0]          req_drop_count,
   output logic signed [bde_pkg::DATA_W-1:0]  rsp_data,
   output logic [bde_pkg::STS_W-1:0]          rsp_status
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = CW + 1;
   localparam int unsigned EW = ((CW > bde_pkg::POS_W) ? CW : bde_pkg::POS_W) + 1;

   logic [bde_pkg::CMD_W-1:0]          cmd_ff;
   logic signed [bde_pkg::DATA_W-1:0]  value_ff;
   logic [bde_pkg::POS_W-1:0]          pos_ff;
   logic [bde_pkg::POS_W-1:0]          drop_ff;

   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic signed [bde_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [bde_pkg::DATA_W-1:0] rd_ff;
   logic signed [bde_pkg::DATA_W-1:0] data_ff;
   logic signed [bde_pkg::DATA_W-1:0] data_in;
   logic [bde_pkg::STS_W-1:0]         status_ff;
   logic [bde_pkg::STS_W-1:0]         status_in;
   logic                              rd_sel_ff;
   logic                              rd_sel_in;

   logic          full;
   logic          empty;
   logic [EW-1:0] pos_ext;
   logic [EW-1:0] drop_ext;
   logic [EW-1:0] count_ext;
   logic          pos_ok;
   logic [CW-1:0] drop_eff;
   logic [CW-1:0] offset;
   logic [SW-1:0] sum;
   logic [AW-1:0] ring_addr;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] addr;
   logic          wr_en;
   logic          rd_en;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         pos_ff   <= req_position;
         drop_ff  <= req_drop_count;
      end
   end

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      pos_ext   = EW'(pos_ff);
      drop_ext  = EW'(drop_ff);
      count_ext = EW'(count_ff);
      pos_ok    = (pos_ff != '0) && (pos_ext <= count_ext);
      drop_eff  = (drop_ext > count_ext) ? count_ff : CW'(drop_ff);

      unique case (cmd_ff)
         bde_pkg::CMD_PUSH_BACK:  offset = count_ff;
         bde_pkg::CMD_POP_BACK:   offset = count_ff - CW'(1);
         bde_pkg::CMD_READ_AT:    offset = CW'(pos_ext - EW'(1));
         bde_pkg::CMD_DROP_FRONT: offset = drop_eff;
         default:                 offset = '0;
      endcase

      sum       = SW'(head_ff) + SW'(offset);
      ring_addr = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
      head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
      addr      = (cmd_ff == bde_pkg::CMD_PUSH_FRONT) ? head_dec : ring_addr;
   end

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_sel_in = 1'b0;
      data_in   = bde_pkg::DATA_ZERO;
      status_in = bde_pkg::STS_OK;
      unique case (cmd_ff)
         bde_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               status_in = bde_pkg::STS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         bde_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = bde_pkg::STS_FULL;
            end else begin
               wr_en    = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + CW'(1);
            end
         end
         bde_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               data_in   = bde_pkg::DATA_NONE;
               status_in = bde_pkg::STS_EMPTY;
            end else begin
               rd_en     = 1'b1;
               rd_sel_in = 1'b1;
               head_in   = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
               count_in  = count_ff - CW'(1);
            end
         end
         bde_pkg::CMD_POP_BACK: begin
            if (empty) begin
               data_in   = bde_pkg::DATA_NONE;
               status_in = bde_pkg::STS_EMPTY;
            end else begin
               rd_en     = 1'b1;
               rd_sel_in = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         bde_pkg::CMD_READ_AT: begin
            if (pos_ok) begin
               rd_en     = 1'b1;
               rd_sel_in = 1'b1;
            end else begin
               data_in   = bde_pkg::DATA_NONE;
               status_in = bde_pkg::STS_RANGE;
            end
         end
         bde_pkg::CMD_DROP_FRONT: begin
            head_in  = ring_addr;
            count_in = count_ff - drop_eff;
         end
         default: begin
            status_in = bde_pkg::STS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (ctl.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && wr_en) begin
         mem[addr] <= value_ff;
      end
      if (ctl.exec && rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   assign rsp_data   = rd_sel_ff ? rd_ff : data_ff;
   assign rsp_status = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !ctl.exec |=> $stable(head_ff) && $stable(count_ff))
      else $error("queue state moved outside exec");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(head_ff) < SW'(DEPTH))
      else $error("head index outside ring");

endmodule

// ===== rtl/core/bounded_deque_engine.sv =====
// A request accepted in idle passes through the execute state, then the response state,
// where the response stays valid until taken; no new request is accepted before that.
// Each request makes a single pass through the ring store port and is held until its
// response is taken. Reset (synchronous, active high) empties the queue: head index and
// count clear to zero, the controller returns to idle; store contents are left as they are.
module bounded_deque_engine #(
   parameter int unsigned DEPTH = 256
) (
   input  logic      clock,
   input  logic      reset,
   bde_req_if.sink   req_ch,
   bde_rsp_if.source rsp_ch
);

   bde_pkg::ctl_type ctl;

   bde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   bde_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_cmd        (req_ch.cmd),
      .req_value      (req_ch.value),
      .req_position   (req_ch.position),
      .req_drop_count (req_ch.drop_count),
      .rsp_data       (rsp_ch.data),
      .rsp_status     (rsp_ch.status)
   );

endmodule
